FILE: design/sdtm_pkg.sv
// Package with shared constants, types and helpers of the stick deadzone track mixer.
package sdtm_pkg;

	localparam int Q14_ONE = 16384;
	localparam int DZ_MAX = 16220;
	localparam int NUM_AXES = 4;
	localparam int AXIS_INPUTS = 4;
	localparam int MAG_W = 15;
	localparam int SQ_W = 30;
	localparam int DIV_NW = 29;
	localparam int DIV_DW = 15;
	localparam int DIV_QW = 15;

	typedef enum logic [2:0] {
		CFG_DEADZONE = 3'd0,
		CFG_PIVOT_THRESHOLD = 3'd1,
		CFG_PIVOT_GAIN = 3'd2,
		CFG_REDUCTION_GAIN = 3'd3,
		CFG_LEFT_INDEX = 3'd4,
		CFG_RIGHT_INDEX = 3'd5
	} cfg_index_t;

	typedef struct packed {
		logic conn;
		logic act;
		logic xneg;
		logic yneg;
		logic [MAG_W-1:0] ax;
		logic [MAG_W-1:0] ay;
		logic brake;
		logic signed [15:0] lev_l;
		logic signed [15:0] lev_r;
	} side_t;

	function automatic logic signed [15:0] clamp_q14(input logic signed [15:0] v);
		logic signed [15:0] r;
		if (v > 16'sd16384) begin
			r = 16'sd16384;
		end else if (v < -16'sd16384) begin
			r = -16'sd16384;
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

FILE: design/sdtm_div_pipe.sv
// Pipelined restoring divider that resolves one quotient bit per stage.
module sdtm_div_pipe import sdtm_pkg::*; #(
	parameter int NW = DIV_NW,
	parameter int DW = DIV_DW,
	parameter int QW = DIV_QW
) (
	input logic clk,
	input logic en,
	input logic [NW-1:0] num,
	input logic [DW-1:0] den,
	output logic [QW-1:0] quo
);

	logic [NW-1:0] rem_s [0:QW];
	logic [DW-1:0] den_s [0:QW];
	logic [QW-1:0] quo_s [0:QW];

	assign rem_s[0] = num;
	assign den_s[0] = den;
	assign quo_s[0] = '0;

	for (genvar g = 0; g < QW; g++) begin : g_step
		localparam int B = QW - 1 - g;
		logic [NW+DW-1:0] sh;
		logic ge;
		assign sh = (NW+DW)'(den_s[g]) << B;
		assign ge = (NW+DW)'(rem_s[g]) >= sh;
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[g+1] <= ge ? NW'((NW+DW)'(rem_s[g]) - sh) : rem_s[g];
				den_s[g+1] <= den_s[g];
				quo_s[g+1] <= ge ? (quo_s[g] | (QW'(1) << B)) : quo_s[g];
			end
		end
	end

	assign quo = quo_s[QW];

endmodule

FILE: design/stick_deadzone_track_mixer_top.sv
// Top level of the stick deadzone track mixer pipeline.
// One word is accepted per cycle while the output is taken; its result passes through the
// 15-stage square root and the two 15-stage dividers in series, one bit per stage. When
// the output is not taken the whole pipeline holds. A configuration write applies to words
// accepted after it; the user must make it only while no word is in flight (not enforced).
module stick_deadzone_track_mixer_top import sdtm_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [2:0] cfg_index,
	input logic [15:0] cfg_data,
	input logic s_tvalid,
	output logic s_tready,
	// stick_x, stick_y, brake_button, axis_zero, axis_one, axis_two, axis_three, axes_present
	input logic [103:0] s_tdata,
	// pad_connected
	input logic [0:0] s_tuser,
	output logic m_tvalid,
	input logic m_tready,
	// throttle_out, steering_out, brake_out, left_lever, right_lever, left_track, right_track
	output logic [103:0] m_tdata
);

	localparam int S_SQ = 3;
	localparam int S_M = S_SQ + MAG_W;
	localparam int S_ND = S_M + 1;
	localparam int S_N = S_ND + DIV_QW;
	localparam int S_PR = S_N + 1;
	localparam int S_Q = S_PR + DIV_QW;
	localparam int S_SG = S_Q + 1;
	localparam int S_ML = S_SG + 1;
	localparam int S_OUT = S_ML + 1;

	logic [13:0] dz_q;
	logic [14:0] pth_q;
	logic [15:0] pg_q;
	logic [15:0] rg_q;
	logic [3:0] li_q;
	logic [3:0] ri_q;
	logic [27:0] dzsq_q;
	logic [13:0] dz_eff;
	logic [14:0] pth_eff;

	logic en;
	logic vl [1:S_OUT];
	side_t sd [1:S_OUT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dz_q <= '0;
			pth_q <= '0;
			pg_q <= 16'd4096;
			rg_q <= 16'd4096;
			li_q <= 4'd0;
			ri_q <= 4'd1;
			dzsq_q <= '0;
		end else begin
			dzsq_q <= 28'(dz_eff) * 28'(dz_eff);
			if (cfg_we) begin
				case (cfg_index)
					CFG_DEADZONE: dz_q <= cfg_data[13:0];
					CFG_PIVOT_THRESHOLD: pth_q <= cfg_data[14:0];
					CFG_PIVOT_GAIN: pg_q <= cfg_data;
					CFG_REDUCTION_GAIN: rg_q <= cfg_data;
					CFG_LEFT_INDEX: li_q <= cfg_data[3:0];
					CFG_RIGHT_INDEX: ri_q <= cfg_data[3:0];
					default: ;
				endcase
			end
		end
	end

	assign dz_eff = (dz_q > 14'(DZ_MAX)) ? 14'(DZ_MAX) : dz_q;
	assign pth_eff = (pth_q > 15'(Q14_ONE)) ? 15'(Q14_ONE) : pth_q;

	assign en = !vl[S_OUT] || m_tready;
	assign s_tready = en;

	// Input stage: clamp, take magnitudes, pick levers.
	logic signed [15:0] xc, yc;
	logic signed [15:0] axes [0:AXIS_INPUTS-1];
	logic [2:0] present;
	side_t sd_in;

	function automatic logic signed [15:0] pick(input logic [3:0] idx, input logic [2:0] pr,
			input logic signed [15:0] a0, input logic signed [15:0] a1,
			input logic signed [15:0] a2, input logic signed [15:0] a3);
		logic signed [15:0] r;
		if (idx >= 4'(pr) || idx >= 4'(NUM_AXES) || idx >= 4'(AXIS_INPUTS)) begin
			r = '0;
		end else begin
			case (idx[1:0])
				2'd0: r = clamp_q14(a0);
				2'd1: r = clamp_q14(a1);
				2'd2: r = clamp_q14(a2);
				default: r = clamp_q14(a3);
			endcase
		end
		return r;
	endfunction

	always_comb begin
		xc = clamp_q14(s_tdata[15:0]);
		yc = clamp_q14(s_tdata[31:16]);
		axes[0] = s_tdata[48:33];
		axes[1] = s_tdata[64:49];
		axes[2] = s_tdata[80:65];
		axes[3] = s_tdata[96:81];
		present = s_tdata[99:97];
		sd_in.conn = s_tuser[0];
		sd_in.act = 1'b0;
		sd_in.xneg = xc[15];
		sd_in.yneg = yc[15];
		sd_in.ax = xc[15] ? MAG_W'(-xc) : MAG_W'(xc);
		sd_in.ay = yc[15] ? MAG_W'(-yc) : MAG_W'(yc);
		sd_in.brake = s_tuser[0] & s_tdata[32];
		sd_in.lev_l = s_tuser[0] ? pick(li_q, present, axes[0], axes[1], axes[2], axes[3]) : '0;
		sd_in.lev_r = s_tuser[0] ? pick(ri_q, present, axes[0], axes[1], axes[2], axes[3]) : '0;
	end

	// Squares and the deadzone test.
	logic [SQ_W-1:0] xx_s2, yy_s2, sq_s3, sq_sum;
	side_t sd_act;
	assign sq_sum = xx_s2 + yy_s2;

	always_comb begin
		sd_act = sd[S_SQ-1];
		sd_act.act = sd[S_SQ-1].conn && (sq_sum > SQ_W'(dzsq_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= S_OUT; k++) begin
				vl[k] <= 1'b0;
			end
		end else if (en) begin
			vl[1] <= s_tvalid;
			for (int k = 2; k <= S_OUT; k++) begin
				vl[k] <= vl[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sd[1] <= sd_in;
			for (int k = 2; k <= S_OUT; k++) begin
				sd[k] <= (k == S_SQ) ? sd_act : sd[k-1];
			end
			xx_s2 <= SQ_W'(sd[1].ax) * SQ_W'(sd[1].ax);
			yy_s2 <= SQ_W'(sd[1].ay) * SQ_W'(sd[1].ay);
			sq_s3 <= sq_sum;
		end
	end

	// Square root, one result bit per stage.
	logic [SQ_W-1:0] sr_rem [0:MAG_W];
	logic [MAG_W-1:0] sr_root [0:MAG_W];
	assign sr_rem[0] = sq_s3;
	assign sr_root[0] = '0;

	for (genvar g = 0; g < MAG_W; g++) begin : g_sqrt
		localparam int B = MAG_W - 1 - g;
		logic [SQ_W:0] t;
		logic ge;
		assign t = ((SQ_W+1)'(sr_root[g]) << (B + 1)) | ((SQ_W+1)'(1) << (2 * B));
		assign ge = (SQ_W+1)'(sr_rem[g]) >= t;
		always_ff @(posedge clk) begin
			if (en) begin
				sr_rem[g+1] <= ge ? SQ_W'((SQ_W+1)'(sr_rem[g]) - t) : sr_rem[g];
				sr_root[g+1] <= ge ? (sr_root[g] | (MAG_W'(1) << B)) : sr_root[g];
			end
		end
	end

	// Rescale numerator and denominator, divide for the scale factor, then scale and divide each axis.
	logic [MAG_W-1:0] m_p [S_ND:S_PR];
	logic [MAG_W-1:0] cm;
	logic [DIV_NW-1:0] num_s19;
	logic [DIV_DW-1:0] den_s19;
	logic [DIV_QW-1:0] n_s34;
	logic [DIV_NW-1:0] px_s35, py_s35;
	logic [DIV_QW-1:0] qx_s50, qy_s50;

	assign cm = (sr_root[MAG_W] > MAG_W'(Q14_ONE)) ? MAG_W'(Q14_ONE) : sr_root[MAG_W];

	always_ff @(posedge clk) begin
		if (en) begin
			m_p[S_ND] <= sr_root[MAG_W];
			for (int k = S_ND + 1; k <= S_PR; k++) begin
				m_p[k] <= m_p[k-1];
			end
			num_s19 <= (cm > MAG_W'(dz_eff)) ? (DIV_NW'(cm - MAG_W'(dz_eff)) << 14) : '0;
			den_s19 <= DIV_DW'(Q14_ONE) - DIV_DW'(dz_eff);
			px_s35 <= DIV_NW'(30'(sd[S_N].ax) * 30'(n_s34));
			py_s35 <= DIV_NW'(30'(sd[S_N].ay) * 30'(n_s34));
		end
	end

	sdtm_div_pipe #(.NW(DIV_NW), .DW(DIV_DW), .QW(DIV_QW)) u_div_n (
		.clk(clk), .en(en), .num(num_s19), .den(den_s19), .quo(n_s34)
	);

	sdtm_div_pipe #(.NW(DIV_NW), .DW(DIV_DW), .QW(DIV_QW)) u_div_x (
		.clk(clk), .en(en), .num(px_s35), .den(m_p[S_PR]), .quo(qx_s50)
	);

	sdtm_div_pipe #(.NW(DIV_NW), .DW(DIV_DW), .QW(DIV_QW)) u_div_y (
		.clk(clk), .en(en), .num(py_s35), .den(m_p[S_PR]), .quo(qy_s50)
	);

	// Signs, gains and the track mix.
	logic [MAG_W-1:0] smag_s51, tmag_s51;
	logic signed [15:0] steer_s51, thr_s51, steer_s52, thr_s52;
	logic [30:0] pm_s52, rm_s52;
	logic piv_s52;
	logic signed [15:0] thr_s53, steer_s53, ltrk_s53, rtrk_s53;
	logic [MAG_W-1:0] pv, red;

	always_comb begin
		pv = (pm_s52[30:12] > 19'(Q14_ONE)) ? MAG_W'(Q14_ONE) : pm_s52[12+MAG_W-1:12];
		red = (rm_s52[30:12] > 19'(Q14_ONE)) ? MAG_W'(Q14_ONE) : rm_s52[12+MAG_W-1:12];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			smag_s51 <= sd[S_Q].act ? qx_s50 : '0;
			tmag_s51 <= sd[S_Q].act ? qy_s50 : '0;
			steer_s51 <= !sd[S_Q].act ? '0 :
				(sd[S_Q].xneg ? -$signed(16'(qx_s50)) : $signed(16'(qx_s50)));
			thr_s51 <= !sd[S_Q].act ? '0 :
				(sd[S_Q].yneg ? -$signed(16'(qy_s50)) : $signed(16'(qy_s50)));
			pm_s52 <= 31'(smag_s51) * 31'(pg_q);
			rm_s52 <= 31'(smag_s51) * 31'(rg_q);
			piv_s52 <= (tmag_s51 <= pth_eff) && (smag_s51 != '0);
			steer_s52 <= steer_s51;
			thr_s52 <= thr_s51;
			steer_s53 <= steer_s52;
			if (piv_s52) begin
				thr_s53 <= $signed(16'(pv));
				ltrk_s53 <= steer_s52[15] ? -16'sd16384 : 16'sd16384;
				rtrk_s53 <= steer_s52[15] ? 16'sd16384 : -16'sd16384;
			end else begin
				thr_s53 <= thr_s52;
				ltrk_s53 <= steer_s52[15] ? 16'sd16384 - $signed(16'(red)) : 16'sd16384;
				rtrk_s53 <= (!steer_s52[15] && steer_s52 != '0) ?
					16'sd16384 - $signed(16'(red)) : 16'sd16384;
			end
		end
	end

	assign m_tvalid = vl[S_OUT];
	assign m_tdata = {7'd0, rtrk_s53, ltrk_s53, sd[S_OUT].lev_r, sd[S_OUT].lev_l,
		sd[S_OUT].brake, steer_s53, thr_s53};

endmodule
